/* design/drlm_pkg.sv */
// ----------------------------------------------------------------------------
// drlm_pkg
// Shared constants and helpers for the dual RMS level meter: sample and level
// formats, the dB scale factor and the log2 routine used for the window term.
// ----------------------------------------------------------------------------
package drlm_pkg;

  localparam int WINDOW_LEN_DEF = 128;
  localparam int SAMPLE_W       = 16;
  localparam int LEVEL_W        = 11;
  localparam int LEVEL_MIN      = -960;
  localparam int LEVEL_MAX      = 96;
  localparam int FRAC_BITS      = 16;
  localparam int MANT_W         = 31;
  // round(160 * log10(2) * 2^16): 1/16 dB per log2 unit in Q.16.
  localparam int DB_K           = 3156528;
  localparam int DB_K_W         = 23;

  // Square of a signed sample; at most 2^30, so 31 bits hold it.
  function automatic logic [MANT_W-1:0] sample_square(input logic signed [SAMPLE_W-1:0] s);
    logic signed [2*SAMPLE_W-1:0] p;
    p = s * s;
    return p[MANT_W-1:0];
  endfunction

  // log2 in Q.16 by repeated squaring of the mantissa, for elaboration only.
  function automatic longint log2_q16_const(input longint unsigned x);
    int              e;
    longint unsigned y;
    longint          frac;
    e    = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        e = i;
      end
    end
    if (e >= 30) begin
      y = x >> (e - 30);
    end else begin
      y = x << (30 - e);
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      y    = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        y    = y >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

endpackage

/* design/drlm_log.sv */
// ----------------------------------------------------------------------------
// drlm_log
// Converts one sum of squares into a level in 1/16 dB: a binary-search
// normalizer, sixteen squaring rounds for the log2 fraction, the window
// correction, one scale multiply and the clamp.
// ----------------------------------------------------------------------------
module drlm_log
  import drlm_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [31+$clog2(WINDOW_LEN)-1:0]  sum,
  output logic                              done,
  output logic signed [LEVEL_W-1:0]         level
);

  localparam int SUM_W   = 31 + $clog2(WINDOW_LEN);
  localparam int NS      = $clog2(SUM_W);
  localparam int STEP_W  = $clog2(NS);
  localparam int E_W     = NS;
  localparam int RND_W   = $clog2(FRAC_BITS);
  localparam int D_W     = 1 + E_W + FRAC_BITS;
  localparam int PROD_W  = D_W + DB_K_W;
  localparam int Q_W     = PROD_W - 32;
  localparam longint LOG_REF = log2_q16_const(longint'(WINDOW_LEN) << 30);

  localparam logic signed [D_W-1:0]    LREF   = D_W'(LOG_REF);
  localparam logic signed [DB_K_W-1:0] K_S    = DB_K_W'(DB_K);
  localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(64'd1 << 31);
  localparam logic signed [Q_W-1:0]    Q_MIN  = Q_W'(LEVEL_MIN);
  localparam logic signed [Q_W-1:0]    Q_MAX  = Q_W'(LEVEL_MAX);

  typedef enum logic [4:0] {
    L_IDLE  = 5'b00001,
    L_NORM  = 5'b00010,
    L_ROUND = 5'b00100,
    L_MUL   = 5'b01000,
    L_OUT   = 5'b10000
  } log_state_t;

  log_state_t               state;
  logic [SUM_W-1:0]         x_reg;
  logic [NS-1:0]            cnt;
  logic [STEP_W-1:0]        step;
  logic [E_W-1:0]           expo;
  logic [MANT_W-1:0]        y;
  logic [FRAC_BITS-1:0]     frac;
  logic [RND_W-1:0]         rnd;
  logic signed [PROD_W-1:0] prod;

  logic [NS:0]              sh;
  logic [SUM_W-1:0]         hi_mask;
  logic                     top_zero;
  logic [SUM_W-1:0]         x_sh;
  logic [NS-1:0]            cnt_sh;
  logic [2*MANT_W-1:0]      sq;
  logic [MANT_W:0]          sq_t;
  logic signed [D_W-1:0]    d;
  logic signed [PROD_W-1:0] t;
  logic signed [Q_W-1:0]    q;

  always_comb begin
    sh       = (NS+1)'(1) << step;
    hi_mask  = ~({SUM_W{1'b1}} >> sh);
    top_zero = (x_reg & hi_mask) == '0;
    x_sh     = top_zero ? (x_reg << sh) : x_reg;
    cnt_sh   = top_zero ? NS'({1'b0, cnt} + sh) : cnt;
    sq       = y * y;
    sq_t     = sq[2*MANT_W-1:MANT_W-1];
    d        = $signed({1'b0, expo, frac}) - LREF;
    t        = prod + HALF;
    q        = t[PROD_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            if (sum == '0) begin
              // Silent window reads as the floor level.
              level <= LEVEL_W'(LEVEL_MIN);
              done  <= 1'b1;
            end else begin
              x_reg <= sum;
              cnt   <= '0;
              step  <= STEP_W'(NS - 1);
              state <= L_NORM;
            end
          end
        end
        L_NORM: begin
          x_reg <= x_sh;
          cnt   <= cnt_sh;
          step  <= step - 1'b1;
          if (step == '0) begin
            y     <= x_sh[SUM_W-1 -: MANT_W];
            expo  <= E_W'(SUM_W - 1) - cnt_sh;
            frac  <= '0;
            rnd   <= '0;
            state <= L_ROUND;
          end
        end
        L_ROUND: begin
          if (sq_t[MANT_W]) begin
            y    <= sq_t[MANT_W:1];
            frac <= {frac[FRAC_BITS-2:0], 1'b1};
          end else begin
            y    <= sq_t[MANT_W-1:0];
            frac <= {frac[FRAC_BITS-2:0], 1'b0};
          end
          rnd <= rnd + 1'b1;
          if (rnd == RND_W'(FRAC_BITS - 1)) begin
            state <= L_MUL;
          end
        end
        L_MUL: begin
          prod  <= d * K_S;
          state <= L_OUT;
        end
        L_OUT: begin
          if (q < Q_MIN) begin
            level <= LEVEL_W'(LEVEL_MIN);
          end else if (q > Q_MAX) begin
            level <= LEVEL_W'(LEVEL_MAX);
          end else begin
            level <= q[LEVEL_W-1:0];
          end
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/dual_rms_level_meter_db_unit.sv */
// ----------------------------------------------------------------------------
// dual_rms_level_meter_db_unit
// Two-channel sliding-window RMS level meter with results in 1/16 dB.
// ----------------------------------------------------------------------------
// m_tvalid rises once the old slot is read, both sums are updated and the shared
// log unit has converted the in sum, then the out sum; a silent channel skips its
// log steps. Items go one at a time, paced by the shared log unit and its
// sixteen squaring rounds per channel, and held back while a result waits.
// Reset: clears control state and the sums; a fill flag makes history slots
// not yet written read as zero, so items are taken right after reset.
module dual_rms_level_meter_db_unit
  import drlm_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // in_sample[15:0], out_sample[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // in_level[10:0], out_level[21:11], zero[23:22]
);

  localparam int AW    = $clog2(WINDOW_LEN);
  localparam int SUM_W = 31 + AW;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_OLD      = 8'b00000010,
    S_SUM      = 8'b00000100,
    S_IN_GO    = 8'b00001000,
    S_IN_WAIT  = 8'b00010000,
    S_OUT_GO   = 8'b00100000,
    S_OUT_WAIT = 8'b01000000,
    S_DONE     = 8'b10000000
  } state_t;

  state_t                    state;
  logic [AW-1:0]             slot;
  logic                      filled;
  logic [2*SAMPLE_W-1:0]     hist_mem [WINDOW_LEN];
  logic [2*SAMPLE_W-1:0]     rd_data;
  logic [2*SAMPLE_W-1:0]     new_pair;
  logic [MANT_W-1:0]         in_new_sq;
  logic [MANT_W-1:0]         out_new_sq;
  logic [MANT_W-1:0]         in_old_sq;
  logic [MANT_W-1:0]         out_old_sq;
  logic [SUM_W-1:0]          in_sum;
  logic [SUM_W-1:0]          out_sum;
  logic signed [LEVEL_W-1:0] in_level;
  logic signed [LEVEL_W-1:0] out_level;
  logic                      log_start;
  logic [SUM_W-1:0]          log_sum;
  logic                      log_done;
  logic signed [LEVEL_W-1:0] log_level;

  assign s_tready  = (state == S_IDLE);
  assign log_start = (state == S_IN_GO) || (state == S_OUT_GO);
  assign log_sum   = (state == S_OUT_GO) ? out_sum : in_sum;

  // History store: both channels share one word per slot.
  always_ff @(posedge clk) begin
    rd_data <= hist_mem[slot];
    if (state == S_OLD) begin
      hist_mem[slot] <= new_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      slot     <= '0;
      filled   <= 1'b0;
      in_sum   <= '0;
      out_sum  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            new_pair   <= s_tdata;
            in_new_sq  <= sample_square(s_tdata[SAMPLE_W-1:0]);
            out_new_sq <= sample_square(s_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            state      <= S_OLD;
          end
        end
        S_OLD: begin
          // Before the first wrap the slot was never written and counts as zero.
          in_old_sq  <= filled ? sample_square(rd_data[SAMPLE_W-1:0]) : '0;
          out_old_sq <= filled ? sample_square(rd_data[2*SAMPLE_W-1:SAMPLE_W]) : '0;
          state      <= S_SUM;
        end
        S_SUM: begin
          in_sum  <= in_sum - SUM_W'(in_old_sq) + SUM_W'(in_new_sq);
          out_sum <= out_sum - SUM_W'(out_old_sq) + SUM_W'(out_new_sq);
          if (slot == AW'(WINDOW_LEN - 1)) begin
            slot   <= '0;
            filled <= 1'b1;
          end else begin
            slot <= slot + 1'b1;
          end
          state <= S_IN_GO;
        end
        S_IN_GO: begin
          state <= S_IN_WAIT;
        end
        S_IN_WAIT: begin
          if (log_done) begin
            in_level <= log_level;
            state    <= S_OUT_GO;
          end
        end
        S_OUT_GO: begin
          state <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (log_done) begin
            out_level <= log_level;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b00, out_level, in_level};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  drlm_log #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .sum   (log_sum),
    .done  (log_done),
    .level (log_level)
  );

endmodule

/* design/drlm_checker.sv */
// ----------------------------------------------------------------------------
// drlm_checker
// Port-level checks for the level meter: output hold, item accounting, input
// busy after a transaction and level range.
// ----------------------------------------------------------------------------
module drlm_checker
  import drlm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic [1:0] pend;
  logic       s_acc;
  logic       m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // Items taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (s_acc && !m_acc) begin
      pend <= pend + 1'b1;
    end else if (m_acc && !s_acc) begin
      pend <= pend - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_acc |-> pend != 2'd0)
    else $error("output transaction without a pending input");

  a_two_max: assert property (@(posedge clk) disable iff (rst)
    pend == 2'd2 |-> !s_tready)
    else $error("input taken with a result waiting and one in work");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:22] == 2'b00
      && $signed(m_tdata[10:0]) >= LEVEL_MIN && $signed(m_tdata[10:0]) <= LEVEL_MAX
      && $signed(m_tdata[21:11]) >= LEVEL_MIN && $signed(m_tdata[21:11]) <= LEVEL_MAX)
    else $error("level out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("input ready right after an input transaction");

endmodule

bind dual_rms_level_meter_db_unit drlm_checker u_drlm_checker (.*);

/* tb/tb_dual_rms_level_meter_db_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_rms_level_meter_db_unit
// Self-checking bench for the two-channel RMS level meter. Sample pairs are
// streamed in under several idle and stall patterns. A behavioral model keeps
// its own sliding windows and square sums and predicts both dB levels of each
// transaction. Every output transaction is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_dual_rms_level_meter_db_unit;
  import drlm_pkg::*;

  localparam int WIN           = WINDOW_LEN_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 120;
  localparam int PHASE_ITEMS   = 70;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] in_level;
    logic signed [LEVEL_W-1:0] out_level;
  } level_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // in_sample[15:0], out_sample[31:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // in_level[10:0], out_level[21:11], zero[23:22]

  // Model state: sample windows, write position and running square sums.
  logic signed [SAMPLE_W-1:0] in_window [WIN];
  logic signed [SAMPLE_W-1:0] out_window [WIN];
  int                         window_pos;
  longint unsigned            in_energy;
  longint unsigned            out_energy;

  level_pair_t level_q[$];
  int          errors = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        hold_start = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  dual_rms_level_meter_db_unit #(
    .WINDOW_LEN(WIN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned sample_energy(input logic signed [SAMPLE_W-1:0] s);
    longint v;
    v = s;
    return longint'(v * v);
  endfunction

  // log2 in Q.16: top bit index plus sixteen fraction bits from squaring a
  // Q2.30 mantissa.
  function automatic longint log2_q16_fixed(input longint unsigned x);
    int              msb;
    longint unsigned m;
    longint          f;
    msb = 63;
    f   = 0;
    while (msb > 0 && !x[msb]) begin
      msb--;
    end
    if (msb >= 30) begin
      m = x >> (msb - 30);
    end else begin
      m = x << (30 - msb);
    end
    repeat (FRAC_BITS) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m[31]) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    return longint'(msb) * 65536 + f;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] db16_level(input longint unsigned energy);
    longint d;
    longint t;
    longint q;
    if (energy == 0) begin
      return LEVEL_W'(LEVEL_MIN);
    end
    d = log2_q16_fixed(energy) - log2_q16_fixed(longint'(WIN) << 30);
    t = d * longint'(DB_K) + (longint'(1) <<< 31);
    // Arithmetic shift floors, also for negative values.
    q = t >>> 32;
    if (q < LEVEL_MIN) begin
      q = LEVEL_MIN;
    end
    if (q > LEVEL_MAX) begin
      q = LEVEL_MAX;
    end
    return q[LEVEL_W-1:0];
  endfunction

  function automatic void predict_levels(input logic [15:0] a, input logic [15:0] b);
    level_pair_t lv;
    in_energy  = in_energy - sample_energy(in_window[window_pos]) + sample_energy(a);
    out_energy = out_energy - sample_energy(out_window[window_pos]) + sample_energy(b);
    in_window[window_pos]  = a;
    out_window[window_pos] = b;
    window_pos = (window_pos == WIN - 1) ? 0 : window_pos + 1;
    lv.in_level  = db16_level(in_energy);
    lv.out_level = db16_level(out_energy);
    level_q.push_back(lv);
  endfunction

  function automatic logic [15:0] next_sample(input int sh);
    logic signed [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return r >>> sh;
    endcase
  endfunction

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    predict_levels(a, b);
  endtask

  task automatic wait_levels_drained();
    s_tvalid <= 1'b0;
    while (level_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_silence_start();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (4) send_pair(16'h0000, 16'h0000);
  endtask

  // Extremes on each channel, asymmetric channels and alternating bit patterns.
  task automatic test_directed_extremes();
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'hFFFF, 16'h0001);
    send_pair(16'h0001, 16'hFFFF);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h8000, 16'h0000);
    send_pair(16'h00FF, 16'hFF00);
    send_pair(16'hFF00, 16'h00FF);
    send_pair(16'h4000, 16'hC000);
    send_pair(16'h8001, 16'h0002);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h0010, 16'hFFF0);
  endtask

  // A window of full-scale samples reaches 0 dB; replacing the in channel with silence
  // must bring its level back down to the floor once the last loud sample leaves.
  task automatic test_full_scale_window();
    tx_idle_pct  = 31;
    rx_stall_pct = 31;
    repeat (WIN + 2) send_pair(16'h8000, 16'h7FFF);
    repeat (WIN + 2) send_pair(16'h0000, 16'h8000);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int sh_in;
    int sh_out;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    sh_in  = 0;
    sh_out = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // Loudness changes in blocks so the levels sweep the whole range.
      if (i % 16 == 0) begin
        sh_in  = $urandom_range(15);
        sh_out = $urandom_range(15);
      end
      send_pair(next_sample(sh_in), next_sample(sh_out));
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0);
    run_random_phase(59, 0);
    run_random_phase(0, 59);
    run_random_phase(31, 31);
  endtask

  // The output side holds off for a long stretch while input keeps coming.
  task automatic test_output_hold_off();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (40) send_pair(next_sample($urandom_range(8)), next_sample($urandom_range(8)));
  endtask

  task automatic test_drain_pause();
    tx_idle_pct  = 0;
    rx_stall_pct = 31;
    repeat (20) send_pair(next_sample($urandom_range(15)), next_sample($urandom_range(15)));
    wait_levels_drained();
    repeat (20) send_pair(next_sample($urandom_range(15)), next_sample($urandom_range(15)));
  endtask

  // Output checker and receiver ready pattern.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (level_q.size() == 0) begin
        $display("%0t: unexpected output transaction, actual in=%0d out=%0d", $time,
                 $signed(m_tdata[10:0]), $signed(m_tdata[21:11]));
        errors++;
      end else begin
        if (m_tdata[10:0] !== level_q[0].in_level) begin
          $display("%0t: in_level mismatch, expected %0d, actual %0d", $time,
                   level_q[0].in_level, $signed(m_tdata[10:0]));
          errors++;
        end
        if (m_tdata[21:11] !== level_q[0].out_level) begin
          $display("%0t: out_level mismatch, expected %0d, actual %0d", $time,
                   level_q[0].out_level, $signed(m_tdata[21:11]));
          errors++;
        end
        void'(level_q.pop_front());
      end
    end
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_dual_rms_level_meter_db_unit failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < WIN; i++) begin
      in_window[i]  = '0;
      out_window[i] = '0;
    end
    window_pos = 0;
    in_energy  = 0;
    out_energy = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_silence_start();
    test_directed_extremes();
    test_full_scale_window();
    test_random_phases();
    test_output_hold_off();
    test_drain_pause();

    s_tvalid <= 1'b0;
    wait_levels_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_dual_rms_level_meter_db_unit passed");
    end else begin
      $display("tb_dual_rms_level_meter_db_unit failed");
    end
    $finish;
  end

endmodule

/* dual_rms_level_meter_db_unit.f */
design/drlm_pkg.sv
design/drlm_log.sv
design/dual_rms_level_meter_db_unit.sv
design/drlm_checker.sv
tb/tb_dual_rms_level_meter_db_unit.sv
